[rtl/mva_pkg.sv]
// ----------------------------------------------------------------------------
// mva_pkg
// Shared types, constants and the velocity curve of the voice allocator.
// ----------------------------------------------------------------------------
package mva_pkg;

    // Number of synthesizer voices (1 to 16)
    localparam int VOICES   = 9;
    localparam int VOICE_W  = 4;
    localparam int VOICE_AW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam logic [VOICE_W-1:0] LAST_VOICE = VOICE_W'(VOICES - 1);

    localparam int NOTE_W  = 8;
    localparam int ATTEN_W = 6;

    // Message kinds (upper nibble of the status byte)
    localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
    localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
    localparam logic [3:0] KIND_CTRL     = 4'hB;

    // Controllers that silence every voice
    localparam logic [7:0] CC_SOUND_OFF = 8'd120;
    localparam logic [7:0] CC_NOTES_OFF = 8'd123;

    localparam logic [1:0] LEN_FULL = 2'd3;

    // Result actions
    localparam logic ACT_KEY_OFF = 1'b0;
    localparam logic ACT_KEY_ON  = 1'b1;

    // Velocity curve modes
    localparam logic [1:0] VEL_FIXED  = 2'd0;
    localparam logic [1:0] VEL_GENTLE = 2'd1;
    localparam logic [1:0] VEL_STEEP  = 2'd2;

    localparam logic [5:0] GENTLE_TOP = 6'd32;
    localparam logic [6:0] STEEP_TOP  = 7'd63;

    // Configuration register indexes
    localparam logic [3:0] REG_CARRIER_BASE = 4'd0;
    localparam logic [3:0] REG_MOD_BASE     = 4'd1;
    localparam logic [3:0] REG_CARRIER_MODE = 4'd2;
    localparam logic [3:0] REG_MOD_MODE     = 4'd3;

    typedef struct packed {
        logic               found;
        logic [VOICE_W-1:0] voice;
    } pick_t;

    function automatic logic [ATTEN_W-1:0] vel_atten(
        input logic [ATTEN_W-1:0] base,
        input logic [1:0]         mode,
        input logic [7:0]         vel
    );
        logic [5:0]         q4;
        logic [6:0]         q2;
        logic [ATTEN_W-1:0] res;
        q4  = vel[7:2];
        q2  = vel[7:1];
        res = base;
        if (mode == VEL_GENTLE)
        begin
            res = (q4 > GENTLE_TOP) ? '0 : ATTEN_W'(GENTLE_TOP - q4);
        end
        else if (mode == VEL_STEEP)
        begin
            res = (q2 > STEEP_TOP) ? '0 : ATTEN_W'(STEEP_TOP - q2);
        end
        return res;
    endfunction

endpackage

[rtl/mva_ram.sv]
// ----------------------------------------------------------------------------
// mva_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mva_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        // hold read data between reads
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/mva_rr_pick.sv]
// ----------------------------------------------------------------------------
// mva_rr_pick
// Round-robin search for the first free voice at or after the pointer.
// ----------------------------------------------------------------------------
module mva_rr_pick (
    input  logic [mva_pkg::VOICES-1:0]  busy,
    input  logic [mva_pkg::VOICE_W-1:0] ptr,
    output mva_pkg::pick_t              pick
);

    logic [mva_pkg::VOICES-1:0]  free;
    logic                        found_hi;
    logic [mva_pkg::VOICE_W-1:0] sel_hi;
    logic [mva_pkg::VOICE_W-1:0] sel_lo;

    assign free = ~busy;

    // lowest free voice at or above ptr, and lowest free voice overall
    always_comb
    begin
        found_hi = 1'b0;
        sel_hi   = '0;
        sel_lo   = '0;
        for (int i = mva_pkg::VOICES - 1; i >= 0; i--)
        begin
            if (free[i])
            begin
                sel_lo = mva_pkg::VOICE_W'(i);
                if (mva_pkg::VOICE_W'(i) >= ptr)
                begin
                    found_hi = 1'b1;
                    sel_hi   = mva_pkg::VOICE_W'(i);
                end
            end
        end
    end

    assign pick.found = |free;
    assign pick.voice = found_hi ? sel_hi : sel_lo;

endmodule

[rtl/midi_voice_allocator.sv]
// ----------------------------------------------------------------------------
// midi_voice_allocator
// Assigns MIDI notes to synthesizer voices and emits key-on/key-off actions.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one MIDI message per transfer.
//   Output channel (out_valid/out_ready) carries the resulting voice actions,
//   zero to VOICES per message, the final one flagged by last.
//   Configuration channel (cfg_valid/cfg_ready) writes the attenuation and
//   velocity-curve registers; cfg_ready is always high.
//   The block works on one message at a time. in_ready is high whenever no
//   message is in work, even while a result waits in the output register.
//   Key-on: the result loads in S_ON once the output is free; a steal loads
//   a key-off there, then the key-on in S_KEYON. Note-off: the note memory
//   is read one voice per cycle, up to the last voice. All-notes-off: one
//   result per cycle unless the output stalls, VOICES in all. Per-message cost is set by
//   the single read port of the note memory and the single output register.
//   A stalled output holds the sequencer whenever it has a result to load.
//   Reset frees every voice, sets the pointer to voice 0 and loads the
//   register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module midi_voice_allocator (
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] status_byte,
    input  logic [7:0] data_one,
    input  logic [7:0] data_two,
    input  logic [1:0] msg_length,

    output logic       out_valid,
    input  logic       out_ready,
    output logic       action,
    output logic [3:0] voice,
    output logic [7:0] note_number,
    output logic [5:0] carrier_atten,
    output logic [5:0] modulator_atten,
    output logic       last,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [3:0] cfg_index,
    input  logic [5:0] cfg_data
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ON     = 3'd1;
    localparam logic [2:0] S_KEYON  = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_ALLOFF = 3'd4;

    localparam int VW = mva_pkg::VOICE_W;
    localparam int AW = mva_pkg::VOICE_AW;

    logic [2:0]                       state_reg, state_next;
    logic [mva_pkg::VOICES-1:0]       busy_reg, busy_next;
    logic [VW-1:0]                    ptr_reg, ptr_next;
    logic [VW-1:0]                    idx_reg, idx_next;
    logic [VW-1:0]                    victim_reg, victim_next;
    logic [mva_pkg::NOTE_W-1:0]       note_reg;
    logic [7:0]                       vel_reg;

    logic [mva_pkg::ATTEN_W-1:0]      car_base_reg, mod_base_reg;
    logic [1:0]                       car_mode_reg, mod_mode_reg;

    logic                             out_valid_reg;
    logic                             action_reg;
    logic [VW-1:0]                    voice_reg;
    logic [mva_pkg::NOTE_W-1:0]       note_out_reg;
    logic [mva_pkg::ATTEN_W-1:0]      car_out_reg, mod_out_reg;
    logic                             last_reg;

    logic                             emit;
    logic                             e_action;
    logic [VW-1:0]                    e_voice;
    logic                             e_last;
    logic                             key_on;
    logic [VW-1:0]                    on_voice;
    logic                             out_free;
    logic                             in_xfer;
    logic [3:0]                       kind;
    logic                             is_on, is_off, is_cc;

    logic                             rd_en;
    logic [AW-1:0]                    rd_addr;
    logic [mva_pkg::NOTE_W-1:0]       rd_data;
    logic                             match;

    mva_pkg::pick_t                   pick;

    mva_rr_pick u_pick (
        .busy (busy_reg),
        .ptr  (ptr_reg),
        .pick (pick)
    );

    mva_ram #(
        .WIDTH (mva_pkg::NOTE_W),
        .DEPTH (mva_pkg::VOICES),
        .AW    (AW)
    ) u_note_ram (
        .clk     (clk),
        .wr_en   (key_on),
        .wr_addr (on_voice[AW-1:0]),
        .wr_data (note_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;

    assign kind   = status_byte[7:4];
    assign is_on  = (msg_length == mva_pkg::LEN_FULL) && (kind == mva_pkg::KIND_NOTE_ON)
                    && (data_two != 8'd0);
    assign is_off = (msg_length == mva_pkg::LEN_FULL)
                    && ((kind == mva_pkg::KIND_NOTE_OFF)
                        || ((kind == mva_pkg::KIND_NOTE_ON) && (data_two == 8'd0)));
    assign is_cc  = (msg_length == mva_pkg::LEN_FULL) && (kind == mva_pkg::KIND_CTRL)
                    && ((data_one == mva_pkg::CC_SOUND_OFF)
                        || (data_one == mva_pkg::CC_NOTES_OFF));

    assign match = busy_reg[idx_reg[AW-1:0]] && (rd_data == note_reg);

    always_comb
    begin
        state_next  = state_reg;
        busy_next   = busy_reg;
        ptr_next    = ptr_reg;
        idx_next    = idx_reg;
        victim_next = victim_reg;
        emit        = 1'b0;
        e_action    = mva_pkg::ACT_KEY_OFF;
        e_voice     = idx_reg;
        e_last      = 1'b1;
        key_on      = 1'b0;
        on_voice    = victim_reg;
        rd_en       = 1'b0;
        rd_addr     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    idx_next = '0;
                    if (is_on)
                    begin
                        state_next = S_ON;
                    end
                    else if (is_off)
                    begin
                        rd_en      = 1'b1;
                        state_next = S_SCAN;
                    end
                    else if (is_cc)
                    begin
                        state_next = S_ALLOFF;
                    end
                end
            end
            S_ON:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (pick.found)
                    begin
                        key_on     = 1'b1;
                        on_voice   = pick.voice;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        // all busy: key off the voice at the pointer, then steal it
                        e_voice     = ptr_reg;
                        e_last      = 1'b0;
                        victim_next = ptr_reg;
                        state_next  = S_KEYON;
                    end
                end
            end
            S_KEYON:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    key_on     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (match)
                begin
                    if (out_free)
                    begin
                        emit                          = 1'b1;
                        busy_next[idx_reg[AW-1:0]]    = 1'b0;
                        state_next                    = S_IDLE;
                    end
                end
                else if (idx_reg == mva_pkg::LAST_VOICE)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    rd_en    = 1'b1;
                    rd_addr  = idx_next[AW-1:0];
                end
            end
            S_ALLOFF:
            begin
                if (out_free)
                begin
                    emit                       = 1'b1;
                    e_last                     = (idx_reg == mva_pkg::LAST_VOICE);
                    busy_next[idx_reg[AW-1:0]] = 1'b0;
                    idx_next                   = idx_reg + 1'b1;
                    if (idx_reg == mva_pkg::LAST_VOICE)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (key_on)
        begin
            e_action                    = mva_pkg::ACT_KEY_ON;
            e_voice                     = on_voice;
            e_last                      = 1'b1;
            busy_next[on_voice[AW-1:0]] = 1'b1;
            ptr_next = (on_voice == mva_pkg::LAST_VOICE) ? '0 : on_voice + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            busy_reg      <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
            car_base_reg  <= 6'd9;
            mod_base_reg  <= 6'd26;
            car_mode_reg  <= mva_pkg::VEL_FIXED;
            mod_mode_reg  <= mva_pkg::VEL_FIXED;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            ptr_reg   <= ptr_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    mva_pkg::REG_CARRIER_BASE: car_base_reg <= cfg_data;
                    mva_pkg::REG_MOD_BASE:     mod_base_reg <= cfg_data;
                    mva_pkg::REG_CARRIER_MODE: car_mode_reg <= cfg_data[1:0];
                    mva_pkg::REG_MOD_MODE:     mod_mode_reg <= cfg_data[1:0];
                    default:                   ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        victim_reg <= victim_next;
        if (in_xfer)
        begin
            note_reg <= data_one;
            vel_reg  <= data_two;
        end
        if (emit)
        begin
            action_reg   <= e_action;
            voice_reg    <= e_voice;
            last_reg     <= e_last;
            note_out_reg <= key_on ? note_reg : '0;
            car_out_reg  <= key_on ? mva_pkg::vel_atten(car_base_reg, car_mode_reg, vel_reg)
                                   : '0;
            mod_out_reg  <= key_on ? mva_pkg::vel_atten(mod_base_reg, mod_mode_reg, vel_reg)
                                   : '0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign action          = action_reg;
    assign voice           = voice_reg;
    assign note_number     = note_out_reg;
    assign carrier_atten   = car_out_reg;
    assign modulator_atten = mod_out_reg;
    assign last            = last_reg;

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= mva_pkg::LAST_VOICE)
        else $error("rotate pointer beyond last voice");

    a_keyon_busy: assert property (@(posedge clk) disable iff (!rst_n)
        key_on |=> busy_reg[$past(on_voice[AW-1:0])])
        else $error("key-on voice not marked busy");

    a_keyoff_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (action == mva_pkg::ACT_KEY_OFF)) |->
        ((note_number == 8'd0) && (carrier_atten == 6'd0) && (modulator_atten == 6'd0)))
        else $error("key-off result carries nonzero payload");

    a_short_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && (msg_length != mva_pkg::LEN_FULL)) |=> (state_reg == S_IDLE))
        else $error("short message started work");

endmodule
